FILE: hdl/ibcc_pkg.sv
// ibcc_pkg: shared types, codes and constants of the IMU bias calibrate and correct block.
// No dependencies; every other file of the block imports it.
`default_nettype none

package ibcc_pkg;

  localparam int RAW_W    = 16;  // raw sensor words
  localparam int ACC_G_W  = 18;  // accel result and stored offsets
  localparam int GYR_W    = 19;  // gyro result
  localparam int TMP_W    = 15;  // temperature result
  localparam int CAL_W    = 16;  // calib_samples register
  localparam int MAG_W    = 18;  // magnitude of a gyro difference or of 5*temp_raw
  localparam int STEP_W   = 6;   // divider step counter
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;
  localparam int NUM_AXES = 6;
  localparam int NUM_ACC  = 3;

  typedef logic [1:0]                kind_t;
  typedef logic [1:0]                status_t;
  typedef logic signed [RAW_W-1:0]   raw_t;
  typedef logic signed [ACC_G_W-1:0] accel_t;
  typedef logic signed [GYR_W-1:0]   gyro_t;
  typedef logic signed [TMP_W-1:0]   temp_t;
  typedef logic [CAL_W-1:0]          cal_t;

  // input kinds
  localparam kind_t KIND_CALIB = 2'd0;
  localparam kind_t KIND_MEAS  = 2'd1;
  localparam kind_t KIND_TEMP  = 2'd2;

  // result status codes
  localparam status_t ST_CAL_TAKEN = 2'd0;
  localparam status_t ST_CAL_DONE  = 2'd1;
  localparam status_t ST_MEAS      = 2'd2;
  localparam status_t ST_TEMP      = 2'd3;

  // register map (word index)
  localparam logic REG_CALIB = 1'b0;
  localparam cal_t CALIB_RST = 16'd64;

  localparam int ONE_G         = 16384;
  localparam int GYRO_DIVISOR  = 131;  // x*256/131
  localparam int TEMP_DIVISOR  = 17;   // x*100/340 == x*5/17
  localparam int TEMP_OFFSET   = 3653;
  localparam int GYRO_STEPS    = 26;   // |d|*256 < 2**26
  localparam int TEMP_STEPS    = 18;   // |5*t| < 2**18

  localparam accel_t ACCEL_MAX = 18'sh1FFFF;
  localparam accel_t ACCEL_MIN = 18'sh20000;
  localparam gyro_t  GYRO_MAX  = 19'sh3FFFF;
  localparam gyro_t  GYRO_MIN  = 19'sh40000;

  // request to the bit-serial divider
  typedef struct packed {
    logic              start;
    logic              neg;
    cal_t              divisor;
    logic [STEP_W-1:0] steps;
  } div_req_t;

endpackage

`default_nettype wire

FILE: hdl/ibcc_if.sv
// ibcc_in_if / ibcc_out_if: valid-ready channels carrying input and result items.
// Depends on ibcc_pkg for the field types.
`default_nettype none

interface ibcc_in_if;
  import ibcc_pkg::*;
  logic  valid;
  logic  ready;
  kind_t kind;
  raw_t  accel_x;
  raw_t  accel_y;
  raw_t  accel_z;
  raw_t  gyro_x;
  raw_t  gyro_y;
  raw_t  gyro_z;
  raw_t  temp_raw;

  modport source (output valid, kind, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                  temp_raw, input ready);
  modport sink   (input valid, kind, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                  temp_raw, output ready);
endinterface

interface ibcc_out_if;
  import ibcc_pkg::*;
  logic    valid;
  logic    ready;
  status_t status;
  accel_t  accel_x_g;
  accel_t  accel_y_g;
  accel_t  accel_z_g;
  gyro_t   gyro_x_dps;
  gyro_t   gyro_y_dps;
  gyro_t   gyro_z_dps;
  temp_t   temp_centi;

  modport source (output valid, status, accel_x_g, accel_y_g, accel_z_g, gyro_x_dps,
                  gyro_y_dps, gyro_z_dps, temp_centi, input ready);
  modport sink   (input valid, status, accel_x_g, accel_y_g, accel_z_g, gyro_x_dps,
                  gyro_y_dps, gyro_z_dps, temp_centi, output ready);
endinterface

`default_nettype wire

FILE: hdl/ibcc_regs.sv
// ibcc_regs: APB-style register file holding calib_samples.
// Depends on ibcc_pkg.
`default_nettype none

module ibcc_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ibcc_pkg::APB_AW-1:0]  paddr,
  input  logic [ibcc_pkg::APB_DW-1:0]  pwdata,
  output logic [ibcc_pkg::APB_DW-1:0]  prdata,
  output logic                         pready,
  output ibcc_pkg::cal_t               calib_o
);
  import ibcc_pkg::*;

  cal_t calib_q;
  logic reg_idx;
  logic wr_en;

  assign reg_idx = paddr[APB_AW-1];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      calib_q <= CALIB_RST;
    end else if (wr_en && (reg_idx == REG_CALIB)) begin
      calib_q <= pwdata[CAL_W-1:0];
    end
  end

  assign prdata  = (reg_idx == REG_CALIB) ? APB_DW'(calib_q) : '0;
  assign calib_o = calib_q;

endmodule

`default_nettype wire

FILE: hdl/ibcc_sdiv.sv
// ibcc_sdiv: bit-serial restoring divider, one quotient bit per cycle, sign applied at the end.
// Dividend arrives as a left-aligned magnitude; depends on ibcc_pkg for the request struct.
`default_nettype none

module ibcc_sdiv #(
  parameter int DW = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ibcc_pkg::div_req_t req_i,
  input  logic [DW-1:0]      dividend_i,
  output logic               done_o,
  output logic [DW-1:0]      quot_o
);
  import ibcc_pkg::*;

  logic [STEP_W-1:0] cnt_q;
  logic              done_q;
  logic [DW-1:0]     x_q, x_d;     // dividend bits out at the top, quotient bits in at the bottom
  cal_t              r_q, r_d;     // partial remainder, always below the divisor
  cal_t              dvs_q;
  logic              neg_q;
  logic [CAL_W:0]    rem;
  logic [CAL_W:0]    rem_sub;
  logic              ge;

  assign rem     = {r_q, x_q[DW-1]};
  assign rem_sub = rem - {1'b0, dvs_q};
  assign ge      = rem >= {1'b0, dvs_q};
  assign r_d     = ge ? rem_sub[CAL_W-1:0] : rem[CAL_W-1:0];
  assign x_d     = {x_q[DW-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == STEP_W'(1)) && !req_i.start;
      if (req_i.start) begin
        cnt_q <= req_i.steps;
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      x_q   <= dividend_i;
      r_q   <= '0;
      dvs_q <= req_i.divisor;
      neg_q <= req_i.neg;
    end else if (cnt_q != '0) begin
      x_q <= x_d;
      r_q <= r_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? (~x_q + DW'(1)) : x_q;

endmodule

`default_nettype wire

FILE: hdl/imu_bias_calibrate_correct_unit.sv
// IMU bias calibrate and correct: one item at a time, result held in an output register.
// A calibration item only adds into the sums; the closing one also divides each axis sum in
// the bit-serial divider, a measurement divides its gyro axes and a temperature item once.
// A new item is taken in the cycle after its result is registered, even if that result is not yet taken.
// Async active-low reset: sums, count and offsets to zero, calib_samples to 64, outputs idle.
`default_nettype none

module imu_bias_calibrate_correct_unit #(
  parameter int ACCUM_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ibcc_pkg::APB_AW-1:0]  paddr,
  input  logic [ibcc_pkg::APB_DW-1:0]  pwdata,
  output logic [ibcc_pkg::APB_DW-1:0]  prdata,
  output logic                         pready,
  ibcc_in_if.sink                      in_i,
  ibcc_out_if.source                   out_o
);
  import ibcc_pkg::*;

  // divider width: wide enough for a sum and for a scaled gyro difference
  localparam int DW   = (ACCUM_WIDTH > GYRO_STEPS) ? ACCUM_WIDTH : GYRO_STEPS;
  localparam int AX_W = 3;
  localparam logic [AX_W-1:0] AX_LAST  = AX_W'(NUM_AXES - 1);
  localparam logic [AX_W-1:0] AX_GYRO0 = AX_W'(NUM_ACC);
  localparam logic [AX_W-1:0] AX_AZ    = AX_W'(2);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_ACC    = 5'b00010,  // add one axis per cycle into its sum
    S_DSTART = 5'b00100,  // launch a divide, or finish an accel axis directly
    S_DWAIT  = 5'b01000,  // wait for the divider, then store its result
    S_EMIT   = 5'b10000   // move the result into the output register
  } state_e;

  state_e               state_q;
  logic [AX_W-1:0]      ax_q;
  cal_t                 cnt_q;
  logic [ACCUM_WIDTH-1:0] sum_q [NUM_AXES];
  accel_t               off_q [NUM_AXES];

  // captured item
  kind_t                kind_q;
  raw_t                 raw_q [NUM_AXES];
  raw_t                 temp_q;

  // result being built
  status_t              status_q;
  accel_t               acc_res_q [NUM_ACC];
  gyro_t                gyr_res_q [NUM_ACC];
  temp_t                tmp_res_q;

  // output register
  logic                 out_valid_q;
  status_t              out_status_q;
  accel_t               out_acc_q [NUM_ACC];
  gyro_t                out_gyr_q [NUM_ACC];
  temp_t                out_tmp_q;

  cal_t                 calib;
  cal_t                 target;
  logic                 in_fire;
  logic                 emit_go;

  // ---------------------------------------------------------------- config
  ibcc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .calib_o (calib)
  );

  // a count of zero behaves as one
  assign target = (calib == '0) ? CAL_W'(1) : calib;

  // ---------------------------------------------------------------- handshakes
  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && (state_q == S_IDLE);
  assign emit_go    = (state_q == S_EMIT) && (!out_valid_q || out_o.ready);

  // ---------------------------------------------------------------- per-axis datapath
  raw_t                   raw_sel;
  accel_t                 off_sel;
  logic [ACCUM_WIDTH-1:0] sum_sel;
  logic [ACCUM_WIDTH-1:0] sum_add;
  cal_t                   cnt_inc;
  logic                   cal_fin;
  logic                   sum_neg;
  logic [ACCUM_WIDTH-1:0] sum_mag;
  logic signed [GYR_W-1:0] diff_w;   // raw - offset, needs one bit over the offset
  logic [GYR_W-1:0]       diff_ng;
  logic [MAG_W-1:0]       diff_mag;
  accel_t                 acc_sat;
  logic signed [GYR_W-1:0] t5;       // 5*temp_raw
  logic [GYR_W-1:0]       t5_ng;
  logic [MAG_W-1:0]       t5_mag;
  logic                   acc_axis;
  logic [1:0]             gidx;

  assign raw_sel = raw_q[ax_q];
  assign off_sel = off_q[ax_q];
  assign sum_sel = sum_q[ax_q];
  assign sum_add = sum_sel + {{(ACCUM_WIDTH-RAW_W){raw_sel[RAW_W-1]}}, raw_sel};

  // count wraps at 16 bits; a wrap also closes the run
  assign cnt_inc = cnt_q + CAL_W'(1);
  assign cal_fin = (cnt_inc >= target) || (cnt_inc == '0);

  assign sum_neg = sum_sel[ACCUM_WIDTH-1];
  assign sum_mag = sum_neg ? (~sum_sel + ACCUM_WIDTH'(1)) : sum_sel;

  assign diff_w   = {{(GYR_W-RAW_W){raw_sel[RAW_W-1]}}, raw_sel} - {off_sel[ACC_G_W-1], off_sel};
  assign diff_ng  = ~diff_w + GYR_W'(1);
  assign diff_mag = diff_w[GYR_W-1] ? diff_ng[MAG_W-1:0] : diff_w[MAG_W-1:0];
  assign acc_sat  = (diff_w[GYR_W-1] != diff_w[GYR_W-2]) ?
                    (diff_w[GYR_W-1] ? ACCEL_MIN : ACCEL_MAX) : diff_w[ACC_G_W-1:0];

  assign t5     = {{(GYR_W-RAW_W-2){temp_q[RAW_W-1]}}, temp_q, 2'b00}
                + {{(GYR_W-RAW_W){temp_q[RAW_W-1]}}, temp_q};
  assign t5_ng  = ~t5 + GYR_W'(1);
  assign t5_mag = t5[GYR_W-1] ? t5_ng[MAG_W-1:0] : t5[MAG_W-1:0];

  assign acc_axis = (kind_q == KIND_MEAS) && (ax_q < AX_GYRO0);
  assign gidx     = 2'(ax_q - AX_GYRO0);

  // ---------------------------------------------------------------- divider
  div_req_t      div_req;
  logic [DW-1:0] div_dividend;
  logic          div_done;
  logic [DW-1:0] quot;

  // magnitudes are placed at the top of the dividend; the step count sets how many
  // bits come in, trailing zeros giving the x256 scaling of the gyro path
  always_comb begin
    div_req       = '0;
    div_dividend  = '0;
    div_req.start = (state_q == S_DSTART) && !acc_axis;
    case (kind_q)
      KIND_CALIB: begin
        div_dividend    = DW'(sum_mag) << (DW - ACCUM_WIDTH);
        div_req.neg     = sum_neg;
        div_req.divisor = target;
        div_req.steps   = STEP_W'(ACCUM_WIDTH);
      end
      KIND_MEAS: begin
        div_dividend    = DW'(diff_mag) << (DW - MAG_W);
        div_req.neg     = diff_w[GYR_W-1];
        div_req.divisor = CAL_W'(GYRO_DIVISOR);
        div_req.steps   = STEP_W'(GYRO_STEPS);
      end
      KIND_TEMP: begin
        div_dividend    = DW'(t5_mag) << (DW - MAG_W);
        div_req.neg     = t5[GYR_W-1];
        div_req.divisor = CAL_W'(TEMP_DIVISOR);
        div_req.steps   = STEP_W'(TEMP_STEPS);
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  ibcc_sdiv #(.DW(DW)) u_sdiv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .dividend_i (div_dividend),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // quotient post-processing
  logic [DW:0]  off_wide;  // average, less 1 g on accel Z
  accel_t       off_sat;
  gyro_t        gyr_sat;
  logic         off_ovf;
  logic         gyr_ovf;

  assign off_wide = {quot[DW-1], quot} - ((ax_q == AX_AZ) ? (DW+1)'(ONE_G) : '0);
  assign off_ovf  = !((&off_wide[DW:ACC_G_W-1]) || !(|off_wide[DW:ACC_G_W-1]));
  assign off_sat  = off_ovf ? (off_wide[DW] ? ACCEL_MIN : ACCEL_MAX) : off_wide[ACC_G_W-1:0];
  assign gyr_ovf  = !((&quot[DW-1:GYR_W-1]) || !(|quot[DW-1:GYR_W-1]));
  assign gyr_sat  = gyr_ovf ? (quot[DW-1] ? GYRO_MIN : GYRO_MAX) : quot[GYR_W-1:0];

  // ---------------------------------------------------------------- control and state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ax_q        <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_AXES; i++) begin
        sum_q[i] <= '0;
        off_q[i] <= '0;
      end
    end else begin
      if (emit_go) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          ax_q <= '0;
          if (in_fire) begin
            case (in_i.kind)
              KIND_CALIB: state_q <= S_ACC;
              KIND_MEAS:  state_q <= S_DSTART;
              KIND_TEMP:  state_q <= S_DSTART;
              default:    state_q <= S_IDLE;  // unknown kind: dropped
            endcase
          end
        end
        S_ACC: begin
          sum_q[ax_q] <= sum_add;
          if (ax_q == AX_LAST) begin
            ax_q <= '0;
            if (cal_fin) begin
              cnt_q   <= '0;
              state_q <= S_DSTART;
            end else begin
              cnt_q   <= cnt_inc;
              state_q <= S_EMIT;
            end
          end else begin
            ax_q <= ax_q + AX_W'(1);
          end
        end
        S_DSTART: begin
          if (acc_axis) begin
            ax_q <= ax_q + AX_W'(1);
          end else begin
            state_q <= S_DWAIT;
          end
        end
        S_DWAIT: begin
          if (div_done) begin
            if (kind_q == KIND_CALIB) begin
              off_q[ax_q] <= off_sat;
              sum_q[ax_q] <= '0;
            end
            if ((kind_q == KIND_TEMP) || (ax_q == AX_LAST)) begin
              state_q <= S_EMIT;
            end else begin
              ax_q    <= ax_q + AX_W'(1);
              state_q <= S_DSTART;
            end
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------- item and result payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q     <= in_i.kind;
      raw_q[0]   <= in_i.accel_x;
      raw_q[1]   <= in_i.accel_y;
      raw_q[2]   <= in_i.accel_z;
      raw_q[3]   <= in_i.gyro_x;
      raw_q[4]   <= in_i.gyro_y;
      raw_q[5]   <= in_i.gyro_z;
      temp_q     <= in_i.temp_raw;
      tmp_res_q  <= '0;
      for (int i = 0; i < NUM_ACC; i++) begin
        acc_res_q[i] <= '0;
        gyr_res_q[i] <= '0;
      end
      case (in_i.kind)
        KIND_CALIB: status_q <= ST_CAL_TAKEN;
        KIND_MEAS:  status_q <= ST_MEAS;
        default:    status_q <= ST_TEMP;
      endcase
    end

    if ((state_q == S_DSTART) && acc_axis) begin
      acc_res_q[ax_q[1:0]] <= acc_sat;
    end

    if ((state_q == S_DWAIT) && div_done) begin
      case (kind_q)
        KIND_CALIB: begin
          if (ax_q == AX_LAST) begin
            status_q <= ST_CAL_DONE;
          end
        end
        KIND_MEAS: begin
          gyr_res_q[gidx] <= gyr_sat;
        end
        KIND_TEMP: begin
          tmp_res_q <= quot[TMP_W-1:0] + TMP_W'(TEMP_OFFSET);
        end
        default: begin
          tmp_res_q <= tmp_res_q;
        end
      endcase
    end

    if (emit_go) begin
      out_status_q <= status_q;
      out_tmp_q    <= tmp_res_q;
      for (int i = 0; i < NUM_ACC; i++) begin
        out_acc_q[i] <= acc_res_q[i];
        out_gyr_q[i] <= gyr_res_q[i];
      end
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.status     = out_status_q;
  assign out_o.accel_x_g  = out_acc_q[0];
  assign out_o.accel_y_g  = out_acc_q[1];
  assign out_o.accel_z_g  = out_acc_q[2];
  assign out_o.gyro_x_dps = out_gyr_q[0];
  assign out_o.gyro_y_dps = out_gyr_q[1];
  assign out_o.gyro_z_dps = out_gyr_q[2];
  assign out_o.temp_centi = out_tmp_q;

endmodule

`default_nettype wire
